[rtl/bfha_pkg.sv]
`default_nettype none
package bfha_pkg;

   localparam int MAX_BLOCKS   = 32;
   localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
   localparam int HEADER_BYTES = 12;
   localparam int OFFSET_BITS  = 24;
   localparam int SPLIT_MIN    = 48;
   localparam int HEAP_MIN     = 64;
   localparam int HEAP_MAX     = 16777216;
   localparam int HEAP_BITS    = 25;
   localparam int REQ_BITS     = 24;
   localparam int ADDR_BITS    = 32;
   localparam int STAMP_BITS   = 32;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 32;
   localparam int HEAP_RESET   = 1048576;

   localparam longint HEAP_LIMIT_RAW = longint'(1) << OFFSET_BITS;
   localparam longint HEAP_LIMIT = (HEAP_LIMIT_RAW > HEAP_MAX) ? HEAP_MAX : HEAP_LIMIT_RAW;

   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAP_BASE  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAP_BYTES = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset;
      logic [OFFSET_BITS-1:0] size;
      logic [STAMP_BITS-1:0]  stamp;
      logic                   is_free;
   } entry_type;

endpackage
`default_nettype wire

[rtl/bfha_req_if.sv]
`default_nettype none
interface bfha_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [bfha_pkg::REQ_BITS-1:0]  request_bytes;
   logic [bfha_pkg::ADDR_BITS-1:0] free_address;

   modport source (output valid, opcode, request_bytes, free_address, input ready);
   modport sink (input valid, opcode, request_bytes, free_address, output ready);
endinterface
`default_nettype wire

[rtl/bfha_rsp_if.sv]
`default_nettype none
interface bfha_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [bfha_pkg::ADDR_BITS-1:0] granted_address;

   modport source (output valid, status, granted_address, input ready);
   modport sink (input valid, status, granted_address, output ready);
endinterface
`default_nettype wire

[rtl/best_fit_heap_allocator_unit.sv]
// Best-fit heap allocator over a table of up to 32 blocks kept in one memory.
// A request beat on req_chan carries an opcode (allocate or free), the bytes
// wanted and the address given back. Each request yields exactly one response
// beat on rsp_chan with a status and, for a granted allocate, the payload
// address.
// A request reads every table entry once through the memory's read port: the
// scan reads each entry and compares it, one state decides, up to two
// write-back states update the table, and then the response register is
// loaded. No new request is accepted until the response register is loaded
// and the unit is back in idle. One request is worked on at a time.
// The response sits in an output register; a new request is accepted while
// that beat still waits, but its result is held until the receiver takes the
// older one. A stalled receiver therefore stops the input once a second result
// is waiting behind the stalled beat.
// Reset, and any write of heap_bytes on the csr port, rebuild the table with
// one free block in the init state, and no request is accepted until the
// rebuild is done. Configuration writes are taken in every cycle.
`default_nettype none
module best_fit_heap_allocator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bfha_req_if.sink                                 req_chan,
   bfha_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [bfha_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [bfha_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int IB = bfha_pkg::IDX_BITS;
   localparam int OB = bfha_pkg::OFFSET_BITS;
   localparam int AB = bfha_pkg::ADDR_BITS;
   localparam int HB = bfha_pkg::HEAP_BITS;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_INIT     = 7'b0000010,
      ST_SCAN     = 7'b0000100,
      ST_DECIDE   = 7'b0001000,
      ST_WB_SPLIT = 7'b0010000,
      ST_WB_BEST  = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [AB-1:0] heap_base_ff;
   logic [HB-1:0] heap_bytes_ff;
   logic          init_pending_ff;
   logic [HB-1:0] heap_write_value;

   bfha_pkg::entry_type mem [bfha_pkg::MAX_BLOCKS];
   bfha_pkg::entry_type rd_ff;
   logic                mem_we;
   logic [IB-1:0]       mem_waddr;
   bfha_pkg::entry_type mem_wdata;

   logic [bfha_pkg::MAX_BLOCKS-1:0] valid_ff;
   logic [bfha_pkg::STAMP_BITS-1:0] stamp_ff;

   logic                            op_ff;
   logic [bfha_pkg::REQ_BITS-1:0]   req_ff;
   logic [AB-1:0]                   rel_ff;
   logic [IB:0]                     issue_ff;
   logic                            cmp_vld_ff;
   logic [IB-1:0]                   cmp_idx_ff;
   logic                            found_ff;
   logic [IB-1:0]                   best_idx_ff;
   bfha_pkg::entry_type             best_ff;
   logic                            slot_found_ff;
   logic [IB-1:0]                   slot_idx_ff;
   logic                            split_ff;
   bfha_pkg::status_type            res_status_ff;
   logic [AB-1:0]                   res_addr_ff;

   logic                            rsp_valid_ff;
   logic [1:0]                      rsp_status_ff;
   logic [AB-1:0]                   rsp_addr_ff;

   logic          req_fire;
   logic          rsp_free;
   logic          cand_ok;
   logic          cand_better;
   logic          free_ok;
   logic [OB-1:0] req_ext;
   logic [OB-1:0] excess;
   logic          split_ok;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !init_pending_ff;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.granted_address = rsp_addr_ff;

   // Clamp the written heap size into the supported range.
   always_comb begin
      heap_write_value = csr_write_data[HB-1:0];
      if (heap_write_value < HB'(bfha_pkg::HEAP_MIN)) begin
         heap_write_value = HB'(bfha_pkg::HEAP_MIN);
      end else if (heap_write_value > HB'(bfha_pkg::HEAP_LIMIT)) begin
         heap_write_value = HB'(bfha_pkg::HEAP_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff    <= '0;
         heap_bytes_ff   <= HB'(bfha_pkg::HEAP_RESET > bfha_pkg::HEAP_LIMIT ?
                                bfha_pkg::HEAP_LIMIT : bfha_pkg::HEAP_RESET);
         init_pending_ff <= 1'b1;
      end else begin
         // A heap_bytes write arriving during the rebuild asks for another one.
         if (csr_write_enable && (csr_index == bfha_pkg::CSR_HEAP_BYTES)) begin
            init_pending_ff <= 1'b1;
         end else if (state_ff == ST_INIT) begin
            init_pending_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               bfha_pkg::CSR_HEAP_BASE: begin
                  heap_base_ff <= csr_write_data[AB-1:0];
               end
               bfha_pkg::CSR_HEAP_BYTES: begin
                  heap_bytes_ff <= heap_write_value;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Entry compare on the registered read data.
   assign req_ext     = OB'(req_ff);
   assign cand_ok     = valid_ff[cmp_idx_ff] && rd_ff.is_free && (rd_ff.size >= req_ext);
   assign cand_better = !found_ff || (rd_ff.size < best_ff.size) ||
                        ((rd_ff.size == best_ff.size) && (rd_ff.stamp > best_ff.stamp));
   assign free_ok     = valid_ff[cmp_idx_ff] && !rd_ff.is_free &&
                        (AB'(rd_ff.offset) == rel_ff);
   assign excess      = best_ff.size - req_ext;
   assign split_ok    = slot_found_ff && (excess >= OB'(bfha_pkg::SPLIT_MIN)) &&
                        (excess >= OB'(bfha_pkg::HEADER_BYTES));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (init_pending_ff) begin
               state_in = ST_INIT;
            end else if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (cmp_vld_ff && (cmp_idx_ff == IB'(bfha_pkg::MAX_BLOCKS - 1))) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               state_in = ST_DONE;
            end else if (op_ff == bfha_pkg::OP_ALLOC && split_ok) begin
               state_in = ST_WB_SPLIT;
            end else begin
               state_in = ST_WB_BEST;
            end
         end
         ST_WB_SPLIT: begin
            state_in = ST_WB_BEST;
         end
         ST_WB_BEST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Write port selection; the read port reads in every cycle, but its data is only
   // used during the scan, when no write takes place.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = best_ff;
      unique case (state_ff)
         ST_INIT: begin
            mem_we            = 1'b1;
            mem_waddr         = '0;
            mem_wdata.offset  = '0;
            mem_wdata.size    = OB'(heap_bytes_ff - HB'(bfha_pkg::HEADER_BYTES));
            mem_wdata.stamp   = '0;
            mem_wdata.is_free = 1'b1;
         end
         ST_WB_SPLIT: begin
            mem_we            = 1'b1;
            mem_waddr         = slot_idx_ff;
            mem_wdata.offset  = best_ff.offset + OB'(bfha_pkg::HEADER_BYTES) + req_ext;
            mem_wdata.size    = excess - OB'(bfha_pkg::HEADER_BYTES);
            mem_wdata.stamp   = stamp_ff;
            mem_wdata.is_free = 1'b1;
         end
         ST_WB_BEST: begin
            mem_we = 1'b1;
            if (op_ff == bfha_pkg::OP_ALLOC) begin
               mem_wdata.is_free = 1'b0;
               if (split_ff) begin
                  mem_wdata.size = req_ext;
               end
            end else begin
               mem_wdata.is_free = 1'b1;
               mem_wdata.stamp   = stamp_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[issue_ff[IB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         stamp_ff     <= 1;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               valid_ff <= bfha_pkg::MAX_BLOCKS'(1);
               stamp_ff <= 1;
            end
            ST_WB_SPLIT: begin
               valid_ff[slot_idx_ff] <= 1'b1;
               stamp_ff              <= stamp_ff + 1'b1;
            end
            ST_WB_BEST: begin
               if (op_ff == bfha_pkg::OP_FREE) begin
                  stamp_ff <= stamp_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
         cmp_vld_ff <= (state_ff == ST_SCAN) &&
                       (issue_ff < (IB + 1)'(bfha_pkg::MAX_BLOCKS));
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= issue_ff[IB-1:0];
      if (req_fire) begin
         op_ff         <= req_chan.opcode;
         req_ff        <= req_chan.request_bytes;
         rel_ff        <= req_chan.free_address - heap_base_ff - AB'(bfha_pkg::HEADER_BYTES);
         issue_ff      <= '0;
         found_ff      <= 1'b0;
         slot_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (issue_ff < (IB + 1)'(bfha_pkg::MAX_BLOCKS)) begin
            issue_ff <= issue_ff + 1'b1;
         end
         if (cmp_vld_ff) begin
            if (op_ff == bfha_pkg::OP_ALLOC) begin
               if (cand_ok && cand_better) begin
                  found_ff    <= 1'b1;
                  best_idx_ff <= cmp_idx_ff;
                  best_ff     <= rd_ff;
               end
            end else if (free_ok && !found_ff) begin
               found_ff    <= 1'b1;
               best_idx_ff <= cmp_idx_ff;
               best_ff     <= rd_ff;
            end
            if (!valid_ff[cmp_idx_ff] && !slot_found_ff) begin
               slot_found_ff <= 1'b1;
               slot_idx_ff   <= cmp_idx_ff;
            end
         end
      end
      if (state_ff == ST_DECIDE) begin
         split_ff    <= (op_ff == bfha_pkg::OP_ALLOC) && split_ok;
         res_addr_ff <= '0;
         if (!found_ff) begin
            res_status_ff <= (op_ff == bfha_pkg::OP_ALLOC) ? bfha_pkg::STATUS_NO_FIT :
                                                             bfha_pkg::STATUS_BAD_FREE;
         end else begin
            res_status_ff <= bfha_pkg::STATUS_OK;
            if (op_ff == bfha_pkg::OP_ALLOC) begin
               res_addr_ff <= heap_base_ff + AB'(best_ff.offset) +
                              AB'(bfha_pkg::HEADER_BYTES);
            end
         end
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

endmodule
`default_nettype wire

[rtl/bfha_checker.sv]
`default_nettype none
module bfha_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [1:0]                    rsp_status,
   input wire logic [bfha_pkg::ADDR_BITS-1:0] rsp_granted_address
);

   // Requests are worked on one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == bfha_pkg::STATUS_OK ||
                     rsp_status == bfha_pkg::STATUS_NO_FIT ||
                     rsp_status == bfha_pkg::STATUS_BAD_FREE))
      else $error("undefined status code");

   a_addr_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bfha_pkg::STATUS_OK) |-> (rsp_granted_address == '0))
      else $error("address given with failing status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
                                     $stable(rsp_granted_address)))
      else $error("stalled response beat changed");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_granted_address (rsp_chan.granted_address)
);
`default_nettype wire
